[rtl/core/i2crt_pkg.sv]
// Shared types and constants for the I2C register transfer master.
package i2crt_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Bits appended to the device address for a read or a write, and the byte MSB mask
	localparam logic       ADDR_READ_BIT  = 1'b1;
	localparam logic       ADDR_WRITE_BIT = 1'b0;
	localparam logic [7:0] BYTE_MSB       = 8'h80;

	typedef enum logic {
		KIND_CMD  = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START1 = 4'd1,
		PH_ADDRW  = 4'd2,
		PH_ACK1   = 4'd3,
		PH_REG    = 4'd4,
		PH_ACK2   = 4'd5,
		PH_START2 = 4'd6,
		PH_ADDRR  = 4'd7,
		PH_ACK3   = 4'd8,
		PH_READ   = 4'd9,
		PH_MACK   = 4'd10,
		PH_WDATA  = 4'd11,
		PH_ACK4   = 4'd12,
		PH_STOP   = 4'd13
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] length;
		logic       is_read;
		logic [7:0] wr_data;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       data_taken;
		logic       done_res;
		logic       status;
		logic       busy_res;
	} result_t;

	// Queue head handshake between front and back
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

[rtl/core/i2crt_if.sv]
// Request and result channel interfaces.
interface i2crt_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [6:0] dev_addr;
	logic [7:0] reg_addr;
	logic [7:0] length;
	logic       is_read;
	logic [7:0] wr_data;
	logic       sda_in;

	modport source (output valid, op, dev_addr, reg_addr, length, is_read, wr_data, sda_in,
		input ready);
	modport sink (input valid, op, dev_addr, reg_addr, length, is_read, wr_data, sda_in,
		output ready);
endinterface

interface i2crt_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       data_taken;
	logic       done_res;
	logic       status;
	logic       busy_res;

	modport source (output valid, scl_level, sda_level, read_byte, read_valid, data_taken,
		done_res, status, busy_res, input ready);
	modport sink (input valid, scl_level, sda_level, read_byte, read_valid, data_taken,
		done_res, status, busy_res, output ready);
endinterface

[rtl/core/i2crt_front.sv]
// Front end: accepts requests, classifies them and queues them for the sequencer.
module i2crt_front (
	input  logic                clk,
	input  logic                arst_n,
	i2crt_in_if.sink            in_ch,
	output i2crt_pkg::queue_head_t head,
	input  logic                pop
);

	i2crt_pkg::item_t                       mem_q [i2crt_pkg::QUEUE_DEPTH];
	logic [i2crt_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [i2crt_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [i2crt_pkg::QUEUE_CNT_W-1:0]      count_q;
	logic                                   push;
	i2crt_pkg::item_t                       item_in;

	always_comb begin
		item_in.kind     = in_ch.op ? i2crt_pkg::KIND_TICK : i2crt_pkg::KIND_CMD;
		item_in.dev_addr = in_ch.dev_addr;
		item_in.reg_addr = in_ch.reg_addr;
		item_in.length   = in_ch.length;
		item_in.is_read  = in_ch.is_read;
		item_in.wr_data  = in_ch.wr_data;
		item_in.sda_in   = in_ch.sda_in;
	end

	assign in_ch.ready = (count_q != i2crt_pkg::QUEUE_CNT_W'(i2crt_pkg::QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign head.valid  = (count_q != '0);
	assign head.item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == i2crt_pkg::QUEUE_PTR_W'(i2crt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == i2crt_pkg::QUEUE_PTR_W'(i2crt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/i2crt_back.sv]
// Back end: bus sequencer, one pin assignment per tick, and the result register.
module i2crt_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2crt_pkg::queue_head_t head,
	output logic                   pop,
	i2crt_out_if.source            out_ch
);

	i2crt_pkg::phase_t phase_q, phase_d;
	logic [1:0]        sub_q, sub_d;
	logic [2:0]        bit_q, bit_d;
	logic [7:0]        byte_q, byte_d;
	logic [7:0]        shift_q, shift_d;
	logic [6:0]        target_q, target_d;
	logic [7:0]        regidx_q, regidx_d;
	logic [7:0]        len_q, len_d;
	logic              rmode_q, rmode_d;
	logic              scl_q, scl_d;
	logic              sda_q, sda_d;

	logic              out_valid_q;
	i2crt_pkg::result_t res_q, res_d;

	logic              tick;
	logic              sda_smp;
	logic [7:0]        shift_src;
	logic [7:0]        byte_inc;
	logic              more_after;
	logic [8:0]        byte_next_w;

	assign pop         = head.valid && (!out_valid_q || out_ch.ready);
	assign tick        = (head.item.kind == i2crt_pkg::KIND_TICK);
	assign sda_smp     = head.item.sda_in;
	assign byte_inc    = byte_q + 8'd1;
	assign byte_next_w = {1'b0, byte_q} + 9'd1;
	// NACK goes out after the last byte of a read
	assign more_after  = (byte_next_w < {1'b0, len_q});
	assign shift_src   = (phase_q == i2crt_pkg::PH_WDATA && sub_q == 2'd0) ?
		head.item.wr_data : shift_q;

	// Next state
	always_comb begin
		phase_d  = phase_q;
		sub_d    = sub_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		shift_d  = shift_q;
		target_d = target_q;
		regidx_d = regidx_q;
		len_d    = len_q;
		rmode_d  = rmode_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		if (pop) begin
			if (!tick) begin
				if (phase_q == i2crt_pkg::PH_IDLE) begin
					target_d = head.item.dev_addr;
					regidx_d = head.item.reg_addr;
					len_d    = head.item.length;
					rmode_d  = head.item.is_read;
					byte_d   = '0;
					phase_d  = i2crt_pkg::PH_START1;
					sub_d    = '0;
					bit_d    = '0;
				end
			end else begin
				unique case (phase_q) inside
					i2crt_pkg::PH_IDLE: begin
					end
					i2crt_pkg::PH_START1, i2crt_pkg::PH_START2: begin
						case (sub_q)
							2'd0: sda_d = 1'b1;
							2'd1: scl_d = 1'b1;
							2'd2: sda_d = 1'b0;
							default: scl_d = 1'b0;
						endcase
						sub_d = sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							sub_d = '0;
							bit_d = '0;
							if (phase_q == i2crt_pkg::PH_START1) begin
								shift_d = {target_q, i2crt_pkg::ADDR_WRITE_BIT};
								phase_d = i2crt_pkg::PH_ADDRW;
							end else begin
								shift_d = {target_q, i2crt_pkg::ADDR_READ_BIT};
								phase_d = i2crt_pkg::PH_ADDRR;
							end
						end
					end
					i2crt_pkg::PH_ADDRW, i2crt_pkg::PH_REG, i2crt_pkg::PH_ADDRR,
					i2crt_pkg::PH_WDATA: begin
						case (sub_q)
							2'd0: begin
								scl_d   = 1'b0;
								shift_d = shift_src;
								sub_d   = 2'd1;
							end
							2'd1: begin
								sda_d   = |(shift_src & i2crt_pkg::BYTE_MSB);
								shift_d = {shift_src[6:0], 1'b0};
								sub_d   = 2'd2;
							end
							2'd2: begin
								scl_d = 1'b1;
								sub_d = 2'd3;
							end
							default: begin
								scl_d = 1'b0;
								if (bit_q == 3'd7) begin
									sub_d = '0;
									bit_d = '0;
									case (phase_q)
										i2crt_pkg::PH_ADDRW: phase_d = i2crt_pkg::PH_ACK1;
										i2crt_pkg::PH_REG:   phase_d = i2crt_pkg::PH_ACK2;
										i2crt_pkg::PH_ADDRR: phase_d = i2crt_pkg::PH_ACK3;
										default:             phase_d = i2crt_pkg::PH_ACK4;
									endcase
								end else begin
									bit_d = bit_q + 3'd1;
									sub_d = 2'd1;
								end
							end
						endcase
					end
					i2crt_pkg::PH_ACK1, i2crt_pkg::PH_ACK2, i2crt_pkg::PH_ACK3,
					i2crt_pkg::PH_ACK4: begin
						case (sub_q)
							2'd0: scl_d = 1'b0;
							2'd1: sda_d = 1'b1;
							2'd2: scl_d = 1'b1;
							default: scl_d = 1'b0;
						endcase
						sub_d = sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							sub_d = '0;
							bit_d = '0;
							case (phase_q)
								i2crt_pkg::PH_ACK1: begin
									if (sda_smp) begin
										phase_d = i2crt_pkg::PH_IDLE;
									end else begin
										shift_d = regidx_q;
										phase_d = i2crt_pkg::PH_REG;
									end
								end
								i2crt_pkg::PH_ACK2: begin
									if (rmode_q) begin
										phase_d = i2crt_pkg::PH_START2;
									end else begin
										phase_d = (byte_q < len_q) ?
											i2crt_pkg::PH_WDATA : i2crt_pkg::PH_STOP;
									end
								end
								i2crt_pkg::PH_ACK3: begin
									phase_d = (byte_q < len_q) ?
										i2crt_pkg::PH_READ : i2crt_pkg::PH_STOP;
								end
								default: begin
									byte_d  = byte_inc;
									phase_d = (byte_inc < len_q) ?
										i2crt_pkg::PH_WDATA : i2crt_pkg::PH_STOP;
								end
							endcase
						end
					end
					i2crt_pkg::PH_READ: begin
						case (sub_q)
							2'd0: begin
								sda_d   = 1'b1;
								shift_d = '0;
								sub_d   = 2'd1;
							end
							2'd1: begin
								scl_d = 1'b0;
								sub_d = 2'd2;
							end
							2'd2: begin
								scl_d = 1'b1;
								sub_d = 2'd3;
							end
							default: begin
								scl_d   = 1'b0;
								shift_d = {shift_q[6:0], sda_smp};
								if (bit_q == 3'd7) begin
									phase_d = i2crt_pkg::PH_MACK;
									sub_d   = '0;
									bit_d   = '0;
								end else begin
									bit_d = bit_q + 3'd1;
									sub_d = 2'd2;
								end
							end
						endcase
					end
					i2crt_pkg::PH_MACK: begin
						case (sub_q)
							2'd0: scl_d = 1'b0;
							2'd1: sda_d = !more_after;
							2'd2: scl_d = 1'b1;
							default: scl_d = 1'b0;
						endcase
						sub_d = sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							byte_d  = byte_inc;
							sub_d   = '0;
							bit_d   = '0;
							phase_d = (byte_inc < len_q) ?
								i2crt_pkg::PH_READ : i2crt_pkg::PH_STOP;
						end
					end
					i2crt_pkg::PH_STOP: begin
						case (sub_q)
							2'd0: scl_d = 1'b0;
							2'd1: sda_d = 1'b0;
							2'd2: scl_d = 1'b1;
							default: sda_d = 1'b1;
						endcase
						sub_d = sub_q + 2'd1;
						if (sub_q == 2'd3) begin
							sub_d   = '0;
							bit_d   = '0;
							phase_d = i2crt_pkg::PH_IDLE;
						end
					end
					default: phase_d = i2crt_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// Result outputs
	always_comb begin
		res_d            = '0;
		res_d.scl_level  = scl_d;
		res_d.sda_level  = sda_d;
		res_d.busy_res   = (phase_d != i2crt_pkg::PH_IDLE);
		if (tick) begin
			if (phase_q == i2crt_pkg::PH_READ && sub_q == 2'd3 && bit_q == 3'd7) begin
				res_d.read_valid = 1'b1;
				res_d.read_byte  = {shift_q[6:0], sda_smp};
			end
			res_d.data_taken = (phase_q == i2crt_pkg::PH_WDATA && sub_q == 2'd0);
			if (sub_q == 2'd3) begin
				if (phase_q == i2crt_pkg::PH_ACK1 && sda_smp) begin
					res_d.done_res = 1'b1;
					res_d.status   = 1'b1;
				end
				if (phase_q == i2crt_pkg::PH_STOP) begin
					res_d.done_res = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2crt_pkg::PH_IDLE;
			sub_q       <= '0;
			bit_q       <= '0;
			byte_q      <= '0;
			shift_q     <= '0;
			target_q    <= '0;
			regidx_q    <= '0;
			len_q       <= '0;
			rmode_q     <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			sub_q    <= sub_d;
			bit_q    <= bit_d;
			byte_q   <= byte_d;
			shift_q  <= shift_d;
			target_q <= target_d;
			regidx_q <= regidx_d;
			len_q    <= len_d;
			rmode_q  <= rmode_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.scl_level  = res_q.scl_level;
	assign out_ch.sda_level  = res_q.sda_level;
	assign out_ch.read_byte  = res_q.read_byte;
	assign out_ch.read_valid = res_q.read_valid;
	assign out_ch.data_taken = res_q.data_taken;
	assign out_ch.done_res   = res_q.done_res;
	assign out_ch.status     = res_q.status;
	assign out_ch.busy_res   = res_q.busy_res;

endmodule

[rtl/core/i2c_register_transfer_master_core.sv]
// I2C register transfer master: every request (command or bus tick) gives one result
// holding the line drives after it. One request per clock is taken in sustained flow while
// results are accepted; each request passes through the two-entry request queue and then
// the result register, and the sequencer makes one step for each request it takes.
// The queue and result register let the request side keep going while results wait.
module i2c_register_transfer_master_core (
	input  logic         clk,
	input  logic         arst_n,
	i2crt_in_if.sink     in_ch,
	i2crt_out_if.source  out_ch
);

	i2crt_pkg::queue_head_t head;
	logic                   pop;

	i2crt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	i2crt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("sequencer took a request from an empty queue");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.done_res) |-> !out_ch.busy_res)
		else $error("transfer reported done while still busy");

	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |-> out_ch.done_res)
		else $error("error status outside the final result");

	a_read_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.read_valid && out_ch.data_taken))
		else $error("read byte and write byte in the same result");

endmodule

[sim/tb.sv]
// Testbench for the I2C register transfer master: predicts the pin result of every request and checks it.
`timescale 1ns / 1ps

module tb;
	import i2crt_pkg::*;

	// Tick index (from 0) of the address ack check, then tick counts of the transfer parts
	localparam int unsigned ACK1_TICK   = 32;
	localparam int unsigned HEAD_TICKS  = 62;
	localparam int unsigned READ_EXTRA  = 33;
	localparam int unsigned READ_BYTE   = 22;
	localparam int unsigned WRITE_BYTE  = 29;
	localparam int unsigned STOP_TICKS  = 4;
	localparam int unsigned RANDOM_REQS = 200;
	localparam int unsigned TAIL_REQS   = 150;
	localparam int unsigned PRINT_CAP   = 50;

	// Pin routines: bit i describes assignment i; on_scl picks the line, lvl the level
	localparam logic [3:0] START_SCL = 4'b1010;
	localparam logic [3:0] START_LVL = 4'b0011;
	localparam logic [3:0] ACK_SCL   = 4'b1101;
	localparam logic [3:0] ACK_LVL   = 4'b0110;
	localparam logic [3:0] STOP_SCL  = 4'b0101;
	localparam logic [3:0] STOP_LVL  = 4'b1100;

	typedef enum {SDA_RANDOM, SDA_HIGH, SDA_LOW} sda_fill_t;

	logic clk = 1'b0;
	logic arst_n;

	i2crt_in_if  req_ch ();
	i2crt_out_if res_ch ();

	i2c_register_transfer_master_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	item_t       pending_req_q[$];
	result_t     expected_pins_q[$];
	int unsigned mismatch_count = 0;
	int unsigned result_count   = 0;
	int unsigned cycle_count    = 0;
	int unsigned cycle_limit    = 32'hFFFF_FFFF;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;

	// Model of the sequencer
	phase_t     bus_phase;
	logic [1:0] bus_sub;
	logic [2:0] bus_bit;
	logic [7:0] bus_bytes;
	logic [7:0] bus_shift;
	logic [7:0] bus_reg;
	logic [7:0] bus_len;
	logic [6:0] bus_dev;
	logic       bus_rd;
	logic       scl_drv;
	logic       sda_drv;

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("tb: mismatch at result %0d: %s", result_count, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function automatic void enter_phase(input phase_t ph);
		bus_phase = ph;
		bus_sub   = 2'd0;
		bus_bit   = 3'd0;
	endfunction

	function automatic bit shift_out_tick();
		bit fin;
		fin = 1'b0;
		case (bus_sub)
		2'd0: begin
			scl_drv = 1'b0;
			bus_sub = 2'd1;
		end
		2'd1: begin
			sda_drv   = bus_shift[7];
			bus_shift = bus_shift << 1;
			bus_sub   = 2'd2;
		end
		2'd2: begin
			scl_drv = 1'b1;
			bus_sub = 2'd3;
		end
		default: begin
			scl_drv = 1'b0;
			if (bus_bit == 3'd7) begin
				fin = 1'b1;
			end else begin
				bus_bit++;
				bus_sub = 2'd1;
			end
		end
		endcase
		return fin;
	endfunction

	function automatic bit pin_quad_tick(input logic [3:0] on_scl, input logic [3:0] lvl);
		if (on_scl[bus_sub])
			scl_drv = lvl[bus_sub];
		else
			sda_drv = lvl[bus_sub];
		if (bus_sub == 2'd3)
			return 1'b1;
		bus_sub++;
		return 1'b0;
	endfunction

	function automatic result_t predict_pins(input item_t it);
		result_t r;
		logic    nack;
		r = '0;
		if (it.kind == KIND_CMD) begin
			// a command while busy is dropped
			if (bus_phase == PH_IDLE) begin
				bus_dev   = it.dev_addr;
				bus_reg   = it.reg_addr;
				bus_len   = it.length;
				bus_rd    = it.is_read;
				bus_bytes = 8'd0;
				enter_phase(PH_START1);
			end
		end else begin
			case (bus_phase)
			PH_IDLE: ;
			PH_START1: if (pin_quad_tick(START_SCL, START_LVL)) begin
				bus_shift = {bus_dev, ADDR_WRITE_BIT};
				enter_phase(PH_ADDRW);
			end
			PH_ADDRW: if (shift_out_tick()) enter_phase(PH_ACK1);
			PH_ACK1: if (pin_quad_tick(ACK_SCL, ACK_LVL)) begin
				if (it.sda_in) begin
					r.done_res = 1'b1;
					r.status   = 1'b1;
					enter_phase(PH_IDLE);
				end else begin
					bus_shift = bus_reg;
					enter_phase(PH_REG);
				end
			end
			PH_REG: if (shift_out_tick()) enter_phase(PH_ACK2);
			PH_ACK2: if (pin_quad_tick(ACK_SCL, ACK_LVL)) begin
				if (bus_rd)
					enter_phase(PH_START2);
				else
					enter_phase(bus_bytes < bus_len ? PH_WDATA : PH_STOP);
			end
			PH_START2: if (pin_quad_tick(START_SCL, START_LVL)) begin
				bus_shift = {bus_dev, ADDR_READ_BIT};
				enter_phase(PH_ADDRR);
			end
			PH_ADDRR: if (shift_out_tick()) enter_phase(PH_ACK3);
			PH_ACK3: if (pin_quad_tick(ACK_SCL, ACK_LVL)) begin
				enter_phase(bus_bytes < bus_len ? PH_READ : PH_STOP);
			end
			PH_READ: begin
				case (bus_sub)
				2'd0: begin
					sda_drv   = 1'b1;
					bus_shift = 8'd0;
					bus_sub   = 2'd1;
				end
				2'd1: begin
					scl_drv = 1'b0;
					bus_sub = 2'd2;
				end
				2'd2: begin
					scl_drv = 1'b1;
					bus_sub = 2'd3;
				end
				default: begin
					scl_drv   = 1'b0;
					bus_shift = {bus_shift[6:0], it.sda_in};
					if (bus_bit == 3'd7) begin
						r.read_byte  = bus_shift;
						r.read_valid = 1'b1;
						enter_phase(PH_MACK);
					end else begin
						bus_bit++;
						bus_sub = 2'd2;
					end
				end
				endcase
			end
			PH_MACK: begin
				// NACK on the last byte, widened so that 255 compares properly
				nack = ({1'b0, bus_bytes} + 9'd1 < {1'b0, bus_len}) ? 1'b0 : 1'b1;
				if (pin_quad_tick(ACK_SCL, {1'b0, 1'b1, nack, 1'b0})) begin
					bus_bytes++;
					enter_phase(bus_bytes < bus_len ? PH_READ : PH_STOP);
				end
			end
			PH_WDATA: begin
				if (bus_sub == 2'd0) begin
					bus_shift    = it.wr_data;
					r.data_taken = 1'b1;
				end
				if (shift_out_tick()) enter_phase(PH_ACK4);
			end
			PH_ACK4: if (pin_quad_tick(ACK_SCL, ACK_LVL)) begin
				bus_bytes++;
				enter_phase(bus_bytes < bus_len ? PH_WDATA : PH_STOP);
			end
			PH_STOP: if (pin_quad_tick(STOP_SCL, STOP_LVL)) begin
				r.done_res = 1'b1;
				enter_phase(PH_IDLE);
			end
			default: bus_phase = PH_IDLE;
			endcase
		end
		r.scl_level = scl_drv;
		r.sda_level = sda_drv;
		r.busy_res  = (bus_phase != PH_IDLE);
		return r;
	endfunction

	function automatic item_t rand_item(input kind_t k);
		item_t it;
		it.kind     = k;
		it.dev_addr = 7'($urandom_range(0, 127));
		it.reg_addr = 8'($urandom_range(0, 255));
		it.length   = 8'($urandom_range(0, 255));
		it.is_read  = 1'($urandom_range(0, 1));
		it.wr_data  = 8'($urandom_range(0, 255));
		it.sda_in   = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// One command and the ticks it needs; spare < 0 cuts it short, meddle_at drops in
	// a command while the transfer is still busy
	task automatic queue_transfer(input logic [6:0] dev, input logic [7:0] rg, input logic [7:0] len,
		input logic rd, input bit addr_ack, input sda_fill_t fill, input int spare,
		input int meddle_at);
		item_t it;
		int    base;
		int    ticks;
		it          = rand_item(KIND_CMD);
		it.dev_addr = dev;
		it.reg_addr = rg;
		it.length   = len;
		it.is_read  = rd;
		pending_req_q.push_back(it);
		if (!addr_ack)
			base = ACK1_TICK + 1;
		else if (rd)
			base = HEAD_TICKS + READ_EXTRA + READ_BYTE * len + STOP_TICKS;
		else
			base = HEAD_TICKS + WRITE_BYTE * len + STOP_TICKS;
		ticks = (base + spare > 1) ? base + spare : 1;
		for (int n = 0; n < ticks; n++) begin
			if (n == meddle_at && n < base)
				pending_req_q.push_back(rand_item(KIND_CMD));
			it = rand_item(KIND_TICK);
			if (fill == SDA_HIGH)
				it.sda_in = 1'b1;
			else if (fill == SDA_LOW)
				it.sda_in = 1'b0;
			if (n == ACK1_TICK)
				it.sda_in = !addr_ack;
			pending_req_q.push_back(it);
		end
	endtask

	function automatic bit idling_allowed();
		return pending_req_q.size() > TAIL_REQS && cycle_count[8:7] != 2'b00;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin : req_driver
		item_t nxt;
		if (arst_n && (!req_ch.valid || req_ch.ready)) begin
			if (gap_left != 0) begin
				gap_left     <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_req_q.size() != 0) begin
				nxt = pending_req_q.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.op       <= nxt.kind;
				req_ch.dev_addr <= nxt.dev_addr;
				req_ch.reg_addr <= nxt.reg_addr;
				req_ch.length   <= nxt.length;
				req_ch.is_read  <= nxt.is_read;
				req_ch.wr_data  <= nxt.wr_data;
				req_ch.sda_in   <= nxt.sda_in;
				if (idling_allowed() && $urandom_range(0, 11) == 0)
					gap_left <= $urandom_range(1, 19);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : pin_monitor
		item_t   seen;
		result_t want;
		if (arst_n) begin
			// predict first so that a result in the same step finds its expectation
			if (req_ch.valid && req_ch.ready) begin
				seen.kind     = kind_t'(req_ch.op);
				seen.dev_addr = req_ch.dev_addr;
				seen.reg_addr = req_ch.reg_addr;
				seen.length   = req_ch.length;
				seen.is_read  = req_ch.is_read;
				seen.wr_data  = req_ch.wr_data;
				seen.sda_in   = req_ch.sda_in;
				expected_pins_q.push_back(predict_pins(seen));
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_pins_q.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_pins_q.pop_front();
					check_field("scl_level", res_ch.scl_level, want.scl_level);
					check_field("sda_level", res_ch.sda_level, want.sda_level);
					check_field("read_byte", res_ch.read_byte, want.read_byte);
					check_field("read_valid", res_ch.read_valid, want.read_valid);
					check_field("data_taken", res_ch.data_taken, want.data_taken);
					check_field("done_res", res_ch.done_res, want.done_res);
					check_field("status", res_ch.status, want.status);
					check_field("busy_res", res_ch.busy_res, want.busy_res);
				end
				result_count++;
			end
			if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (idling_allowed() && $urandom_range(0, 9) == 0)
					stall_left <= $urandom_range(1, 19);
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned random_base;
		int          spare;
		int          meddle_at;
		logic [7:0]  len;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.op       = KIND_TICK;
		req_ch.dev_addr = '0;
		req_ch.reg_addr = '0;
		req_ch.length   = '0;
		req_ch.is_read  = 1'b0;
		req_ch.wr_data  = '0;
		req_ch.sda_in   = 1'b0;
		res_ch.ready    = 1'b0;

		bus_phase = PH_IDLE;
		bus_sub   = '0;
		bus_bit   = '0;
		bus_bytes = '0;
		bus_shift = '0;
		bus_reg   = '0;
		bus_len   = '0;
		bus_dev   = '0;
		bus_rd    = 1'b0;
		scl_drv   = 1'b1;
		sda_drv   = 1'b1;

		// ticks while idle change nothing
		pending_req_q.push_back(rand_item(KIND_TICK));
		pending_req_q.push_back(rand_item(KIND_TICK));
		// zero-length write goes straight to stop; zero-length read still re-addresses
		queue_transfer(7'h7F, 8'hFF, 8'd0, 1'b0, 1'b1, SDA_LOW, 1, -1);
		queue_transfer(7'h00, 8'h00, 8'd0, 1'b1, 1'b1, SDA_HIGH, 1, -1);
		// address NACK: no stop, then idle ticks
		queue_transfer(7'h55, 8'hA5, 8'd255, 1'b0, 1'b0, SDA_RANDOM, 3, -1);
		queue_transfer(7'h2A, 8'h5A, 8'd1, 1'b1, 1'b1, SDA_HIGH, 0, -1);
		queue_transfer(7'h11, 8'h3C, 8'd2, 1'b1, 1'b1, SDA_LOW, 0, -1);
		// command while busy must be ignored
		queue_transfer(7'h6E, 8'hC3, 8'd2, 1'b0, 1'b1, SDA_RANDOM, 0, 40);

		random_base = pending_req_q.size();
		while (pending_req_q.size() - random_base < RANDOM_REQS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				queue_transfer(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, SDA_RANDOM,
					int'($urandom_range(0, 3)), -1);
			end else if (pick < 12) begin
				// loose requests of either kind
				repeat ($urandom_range(1, 6))
					pending_req_q.push_back(rand_item(kind_t'($urandom_range(0, 1))));
			end else begin
				len       = (pick < 90) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(5, 16));
				spare     = ($urandom_range(0, 19) == 0) ? -int'($urandom_range(1, 40))
					: int'($urandom_range(0, 2));
				meddle_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 60)) : -1;
				queue_transfer(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), len,
					1'($urandom_range(0, 1)), 1'b1, sda_fill_t'($urandom_range(0, 2)), spare,
					meddle_at);
			end
		end
		cycle_limit = pending_req_q.size() * 120 + 10000;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req_q.size() != 0 || req_ch.valid) @(posedge clk);
		while (expected_pins_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
